[design/bfpu_pkg.sv]
// Shared types, constants and the character code function of the bit-field pack and unpack engine.
package bfpu_pkg;

  localparam int BUFFER_BYTES_DEF = 128;
  localparam int WORD_BITS        = 64;
  localparam int START_BITS       = 10;
  localparam int WIDTH_BITS       = 7;
  localparam int CHAR_BITS        = 6;
  localparam int MAX_FIELD_BITS   = 64;

  typedef enum logic [1:0] {
    REQ_WRITE_FIELD = 2'd0,
    REQ_WRITE_CHAR  = 2'd1,
    REQ_READ_U      = 2'd2,
    REQ_READ_S      = 2'd3
  } req_e;

  typedef struct packed {
    logic       bad;
    logic [5:0] code;
  } char_code_t;

  function automatic char_code_t six_bit_code(input logic [7:0] c);
    char_code_t r;
    if ((c >= 8'h20) && (c <= 8'h5F)) begin
      r.bad  = 1'b0;
      r.code = c[5:0];
    end else begin
      r.bad  = 1'b1;
      r.code = 6'd0;
    end
    return r;
  endfunction

endpackage

[design/bfpu_ram.sv]
// Generic single-write, single-read synchronous RAM with a registered read port.
module bfpu_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 16,
  localparam int AddrW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AddrW-1:0] waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AddrW-1:0] raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

[design/bitfield_pack_unpack_engine.sv]
// Top level of the big-endian bit-field pack and unpack engine.
// The message buffer is held as 64-bit words split over two RAM banks, even words in one and odd
// words in the other, so the two words that a field of up to 64 bits can touch are read together.
// One item at a time occupies the block and passes through its steps: the accepting cycle, the RAM read,
// alignment, then merge, write-back and result load. The block returns to idle, ready for the
// next item, in the same cycle that the result becomes valid. The last step waits
// while an earlier result is still held in the output register and not taken, and a new item is
// accepted while such a result waits. After reset a clearing pass zeroes both banks, and no
// item is accepted during it.
module bitfield_pack_unpack_engine #(
  parameter int BUFFER_BYTES = bfpu_pkg::BUFFER_BYTES_DEF
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  // [9:0] bit_start, [16:10] field_width, [80:17] write_value, [87:81] zero
  input  logic [87:0] s_axis_tdata,
  // [1:0] req_type
  input  logic [1:0]  s_axis_tuser,
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // [63:0] read_data
  output logic [63:0] m_axis_tdata,
  // [0] range_error, [1] bad_char
  output logic [1:0]  m_axis_tuser
);

  import bfpu_pkg::*;

  localparam int ROWS       = (BUFFER_BYTES + 7) / 8;
  localparam int BANK_DEPTH = ROWS / 2 + 1;
  localparam int BANK_AW    = (BANK_DEPTH > 1) ? $clog2(BANK_DEPTH) : 1;
  localparam int BUF_BITS   = BUFFER_BYTES * 8;
  localparam int ROW_BITS   = START_BITS - 6;

  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_READ,
    S_ALIGN,
    S_DONE
  } state_e;

  state_e              state_q, state_d;
  logic [BANK_AW-1:0]  clr_q, clr_d;
  logic                m_valid_q, m_valid_d;
  logic [63:0]         m_data_q, m_data_d;
  logic [1:0]          m_user_q, m_user_d;

  req_e                 req_q;
  logic [START_BITS-1:0] start_q;
  logic [WIDTH_BITS-1:0] width_q;
  logic [63:0]          val_q;
  logic                 rerr_q;
  logic                 bad_q;
  logic [127:0]         cat_q;
  logic [63:0]          shl_q;
  logic [127:0]         mask_q;
  logic [127:0]         ins_q;

  req_e                  in_type;
  logic [START_BITS-1:0] in_start;
  logic [WIDTH_BITS-1:0] in_width;
  logic [63:0]           in_value;
  char_code_t            in_char;
  logic [WIDTH_BITS-1:0] eff_w;
  logic [START_BITS:0]   in_sum;
  logic                  in_rng;
  logic [63:0]           wmask;
  logic [63:0]           val_d;
  logic                  accept;

  logic [ROW_BITS-1:0]   row;
  logic [ROW_BITS:0]     row_up;
  logic [BANK_AW+ROW_BITS-1:0] a0_wide, a1_wide;
  logic [BANK_AW-1:0]    addr0, addr1;
  logic                  we0, re0;
  logic [63:0]           wdata0, wdata1;
  logic [63:0]           rdata0, rdata1;

  logic [127:0]          cat_d;
  logic [127:0]          cat_shl;
  logic [5:0]            offs;
  logic [7:0]            end_bit;
  logic [7:0]            end_rnd;
  logic [127:0]          mask_d;
  logic [127:0]          ins_d;

  logic [63:0]           rd_raw;
  logic [5:0]            sign_idx;
  logic [63:0]           rd_val;
  logic [127:0]          merged;
  logic                  is_read;
  logic                  is_write;
  logic                  out_free;

  assign in_type  = req_e'(s_axis_tuser);
  assign in_start = s_axis_tdata[9:0];
  assign in_width = s_axis_tdata[16:10];
  assign in_value = s_axis_tdata[80:17];
  assign in_char  = six_bit_code(in_value[7:0]);
  assign eff_w    = (in_type == REQ_WRITE_CHAR) ? WIDTH_BITS'(CHAR_BITS) : in_width;
  assign in_sum   = {1'b0, in_start} + (START_BITS + 1)'(eff_w);
  assign in_rng   = (eff_w <= WIDTH_BITS'(MAX_FIELD_BITS)) &&
                    (32'(in_sum) <= 32'(BUF_BITS));
  assign wmask    = (eff_w >= WIDTH_BITS'(MAX_FIELD_BITS)) ? {64{1'b1}} :
                    ~({64{1'b1}} << eff_w);

  always_comb begin
    case (in_type)
      REQ_WRITE_FIELD: val_d = in_value & wmask;
      REQ_WRITE_CHAR:  val_d = {58'd0, in_char.code};
      default:         val_d = 64'd0;
    endcase
  end

  assign accept        = s_axis_tvalid && s_axis_tready;
  assign s_axis_tready = (state_q == S_IDLE);

  assign row     = start_q[START_BITS-1:6];
  assign row_up  = ({1'b0, row} + (ROW_BITS + 1)'(1)) >> 1;
  assign a0_wide = {{BANK_AW{1'b0}}, row_up[ROW_BITS-1:0]};
  assign a1_wide = {{BANK_AW{1'b0}}, 1'b0, row[ROW_BITS-1:1]};

  assign is_read  = (req_q == REQ_READ_U) || (req_q == REQ_READ_S);
  assign is_write = !is_read && !rerr_q;
  assign out_free = !m_valid_q || m_axis_tready;

  assign merged = (cat_q & ~mask_q) | (ins_q & mask_q);

  always_comb begin
    if (state_q == S_CLEAR) begin
      addr0  = clr_q;
      addr1  = clr_q;
      wdata0 = 64'd0;
      wdata1 = 64'd0;
      we0    = 1'b1;
    end else begin
      addr0  = a0_wide[BANK_AW-1:0];
      addr1  = a1_wide[BANK_AW-1:0];
      wdata0 = row[0] ? merged[63:0] : merged[127:64];
      wdata1 = row[0] ? merged[127:64] : merged[63:0];
      we0    = (state_q == S_DONE) && out_free && is_write;
    end
  end

  assign re0 = (state_q == S_READ);

  bfpu_ram #(
    .WIDTH (WORD_BITS),
    .DEPTH (BANK_DEPTH)
  ) u_bank_even (
    .clk_i   (clk_i),
    .we_i    (we0),
    .waddr_i (addr0),
    .wdata_i (wdata0),
    .re_i    (re0),
    .raddr_i (addr0),
    .rdata_o (rdata0)
  );

  bfpu_ram #(
    .WIDTH (WORD_BITS),
    .DEPTH (BANK_DEPTH)
  ) u_bank_odd (
    .clk_i   (clk_i),
    .we_i    (we0),
    .waddr_i (addr1),
    .wdata_i (wdata1),
    .re_i    (re0),
    .raddr_i (addr1),
    .rdata_o (rdata1)
  );

  assign cat_d   = row[0] ? {rdata1, rdata0} : {rdata0, rdata1};
  assign offs    = start_q[5:0];
  assign cat_shl = cat_d << offs;
  assign end_bit = {2'b00, offs} + {1'b0, width_q};
  assign end_rnd = (width_q == '0) ? {2'b00, offs} : ((end_bit + 8'd7) & 8'hF8);
  assign mask_d  = ({128{1'b1}} >> offs) & ~({128{1'b1}} >> end_rnd);
  assign ins_d   = {64'd0, val_q} << (8'd128 - end_bit);

  assign rd_raw   = shl_q >> (WIDTH_BITS'(MAX_FIELD_BITS) - width_q);
  assign sign_idx = 6'(width_q - WIDTH_BITS'(1));

  always_comb begin
    rd_val = rd_raw;
    if ((req_q == REQ_READ_S) && (width_q != '0) && rd_raw[sign_idx]) begin
      rd_val = rd_raw | ({64{1'b1}} << sign_idx);
    end
    if (!is_read || rerr_q) begin
      rd_val = 64'd0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      req_q   <= in_type;
      start_q <= in_start;
      width_q <= eff_w;
      val_q   <= val_d;
      rerr_q  <= !in_rng;
      bad_q   <= (in_type == REQ_WRITE_CHAR) && in_char.bad;
    end
    if (state_q == S_ALIGN) begin
      cat_q  <= cat_d;
      shl_q  <= cat_shl[127:64];
      mask_q <= mask_d;
      ins_q  <= ins_d;
    end
  end

  always_comb begin
    state_d   = state_q;
    clr_d     = clr_q;
    m_valid_d = m_valid_q;
    m_data_d  = m_data_q;
    m_user_d  = m_user_q;
    if (m_valid_q && m_axis_tready) begin
      m_valid_d = 1'b0;
    end
    unique case (state_q)
      S_CLEAR: begin
        clr_d = clr_q + BANK_AW'(1);
        if (clr_q == BANK_AW'(BANK_DEPTH - 1)) begin
          state_d = S_IDLE;
        end
      end
      S_IDLE: begin
        if (accept) begin
          state_d = S_READ;
        end
      end
      S_READ:  state_d = S_ALIGN;
      S_ALIGN: state_d = S_DONE;
      S_DONE: begin
        if (out_free) begin
          m_valid_d = 1'b1;
          m_data_d  = rd_val;
          m_user_d  = {bad_q, rerr_q};
          state_d   = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= S_CLEAR;
      clr_q     <= '0;
      m_valid_q <= 1'b0;
      m_data_q  <= 64'd0;
      m_user_q  <= 2'd0;
    end else begin
      state_q   <= state_d;
      clr_q     <= clr_d;
      m_valid_q <= m_valid_d;
      m_data_q  <= m_data_d;
      m_user_q  <= m_user_d;
    end
  end

  assign m_axis_tvalid = m_valid_q;
  assign m_axis_tdata  = m_data_q;
  assign m_axis_tuser  = m_user_q;

endmodule

[design/bfpu_checker.sv]
// Port-level checker of the bit-field pack and unpack engine and its bind statement.
module bfpu_port_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        s_axis_tvalid,
  input logic        s_axis_tready,
  input logic        m_axis_tvalid,
  input logic        m_axis_tready,
  input logic [63:0] m_axis_tdata,
  input logic [1:0]  m_axis_tuser
);

  // A result that is not taken stays as it is.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=>
      m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser))
    else $error("held result changed");

  // Only one item is in work at a time.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
    else $error("item accepted while another is in work");

  // A range error returns no data.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tuser[0] |-> m_axis_tdata == 64'd0)
    else $error("data returned with a range error");

  // A bad character can come only from a write, which returns no data.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tuser[1] |-> m_axis_tdata == 64'd0)
    else $error("data returned with a bad character");

endmodule

bind bitfield_pack_unpack_engine bfpu_port_checker u_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .s_axis_tvalid (s_axis_tvalid),
  .s_axis_tready (s_axis_tready),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata),
  .m_axis_tuser  (m_axis_tuser)
);
